[src/cgl_pkg.sv]
// Shared types, register codes and reset values for the color gradient lookup.
package cgl_pkg;

    localparam int CFG_INDEX_W      = 3;
    localparam int STOP_W           = 41;
    localparam int POS_W            = 17;
    localparam int CNT_W            = 3;
    localparam int NUM_STOP_REGS    = 7;
    localparam int NUM_CH           = 3;
    localparam int CHAN_FIELD_W     = 8;
    localparam int CHAN_PORT_W      = 8;
    localparam int POS_LSB          = NUM_CH * CHAN_FIELD_W;
    localparam int DEF_MAX_STOPS    = 7;
    localparam int DEF_CHANNEL_BITS = 8;

    localparam logic [CNT_W-1:0] STOP_COUNT_RESET = CNT_W'(5);

    // Blue, cyan, green, yellow and red at 0.0, 0.25, 0.5, 0.75 and 1.0.
    localparam logic [STOP_W-1:0] STOP_RESET [NUM_STOP_REGS] = '{
        41'd255,
        41'd274877972479,
        41'd549755879168,
        41'd824650497792,
        41'd1099528339456,
        41'd0,
        41'd0
    };

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_STOP_COUNT,
        REG_STOP_0,
        REG_STOP_1,
        REG_STOP_2,
        REG_STOP_3,
        REG_STOP_4,
        REG_STOP_5,
        REG_STOP_6
    } cfg_reg_t;

    // Control that travels alongside each word through the pipeline.
    typedef struct packed {
        logic valid;
        logic empty;
    } cgl_tag_t;

endpackage

[src/cgl_divider.sv]
// Pipelined saturating divider and clamp stage for the three color channels.
module cgl_divider
    import cgl_pkg::*;
#(
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  cgl_tag_t                                  in_tag,
    input  logic [NUM_CH-1:0][CHANNEL_BITS+POS_W-1:0] in_num,
    input  logic [POS_W-1:0]                          in_den,
    input  logic [NUM_CH-1:0]                         in_neg,
    input  logic [NUM_CH-1:0][CHANNEL_BITS-1:0]       in_chan,
    output cgl_tag_t                                  out_tag,
    output logic [NUM_CH-1:0][CHANNEL_BITS-1:0]       out_chan
);

    localparam int CB = CHANNEL_BITS;
    localparam int QB = CB + 1;
    localparam int RW = POS_W + QB;
    localparam int VW = CB + 3;
    localparam logic [CB-1:0] CH_MAX = '1;

    cgl_tag_t                      tag_reg  [QB+1];
    logic [NUM_CH-1:0][RW-1:0]     rem_reg  [QB+1];
    logic [NUM_CH-1:0][QB-1:0]     quo_reg  [QB+1];
    logic [NUM_CH-1:0]             neg_reg  [QB+1];
    logic [NUM_CH-1:0]             sat_reg  [QB+1];
    logic [NUM_CH-1:0][CB-1:0]     chan_reg [QB+1];
    logic [POS_W-1:0]              den_reg  [QB+1];

    logic [NUM_CH-1:0]             sat_next;
    logic [NUM_CH-1:0][CB-1:0]     out_chan_next;
    logic [NUM_CH-1:0][CB-1:0]     out_chan_reg;
    cgl_tag_t                      out_tag_reg;

    // A quotient that needs more than QB bits saturates; the clamp makes it exact.
    always_comb
    begin
        for (int k = 0; k < NUM_CH; k++)
        begin
            sat_next[k] = RW'(in_num[k]) >= (RW'(in_den) << QB);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0] <= '0;
        end
        else
        begin
            tag_reg[0] <= in_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_CH; k++)
        begin
            rem_reg[0][k] <= RW'(in_num[k]);
        end
        quo_reg[0]  <= '0;
        neg_reg[0]  <= in_neg;
        sat_reg[0]  <= sat_next;
        chan_reg[0] <= in_chan;
        den_reg[0]  <= in_den;
    end

    // One restoring step per stage, most significant quotient bit first.
    for (genvar j = 0; j < QB; j++)
    begin : g_step
        localparam int B = QB - 1 - j;

        logic [RW-1:0]             trial;
        logic [NUM_CH-1:0][RW-1:0] rem_next;
        logic [NUM_CH-1:0][QB-1:0] quo_next;

        always_comb
        begin
            trial = RW'(den_reg[j]) << B;
            for (int k = 0; k < NUM_CH; k++)
            begin
                rem_next[k] = rem_reg[j][k];
                quo_next[k] = quo_reg[j][k];
                if (rem_reg[j][k] >= trial)
                begin
                    rem_next[k]    = rem_reg[j][k] - trial;
                    quo_next[k][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[j+1] <= '0;
            end
            else
            begin
                tag_reg[j+1] <= tag_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j+1]  <= rem_next;
            quo_reg[j+1]  <= quo_next;
            neg_reg[j+1]  <= neg_reg[j];
            sat_reg[j+1]  <= sat_reg[j];
            chan_reg[j+1] <= chan_reg[j];
            den_reg[j+1]  <= den_reg[j];
        end
    end

    always_comb
    begin
        logic [QB-1:0]        qmag;
        logic signed [VW-1:0] qs;
        logic signed [VW-1:0] v;
        for (int k = 0; k < NUM_CH; k++)
        begin
            qmag = sat_reg[QB][k] ? '1 : quo_reg[QB][k];
            qs   = $signed(VW'(qmag));
            v    = $signed(VW'(chan_reg[QB][k])) + (neg_reg[QB][k] ? -qs : qs);
            if (tag_reg[QB].empty || v[VW-1])
            begin
                out_chan_next[k] = '0;
            end
            else if (v[VW-2:0] > (VW-1)'(CH_MAX))
            begin
                out_chan_next[k] = CH_MAX;
            end
            else
            begin
                out_chan_next[k] = v[CB-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_tag_reg <= '0;
        end
        else
        begin
            out_tag_reg <= tag_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        out_chan_reg <= out_chan_next;
    end

    assign out_tag  = out_tag_reg;
    assign out_chan = out_chan_reg;

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        in_tag.valid |-> in_den != '0)
        else $error("divider entered with a zero divisor");

endmodule

[src/color_gradient_lookup.sv]
// Top level of the color gradient lookup: stop registers, stop search and operand stages.
//
// The block maps one unsigned Q1.16 sample to an RGB color by linear
// interpolation between up to seven color stops held in configuration registers.
// Software writes the stops in ascending position order through the write port
// (cfg_write, cfg_index, cfg_data), only while no word is in flight.
// A word is accepted at each rising edge where start is high and busy is low.
// busy never rises, so one word can be accepted in every cycle.
// The result appears on out_red, out_green, out_blue and gradient_empty for
// exactly one cycle, marked by done.
// The receiver cannot stall: results are never held, and since the pipeline
// advances every cycle none is ever lost.
// An accepted word passes through the search, operand and multiply stages, the
// divider's input register, CHANNEL_BITS + 1 divider stages that each resolve one
// quotient bit, and the divider's output register.
// Reset empties the pipeline and restores the default five-stop gradient
// running blue, cyan, green, yellow, red over 0.0 to 1.0.
// A stop count of zero yields zero colors with gradient_empty set.
module color_gradient_lookup
    import cgl_pkg::*;
#(
    parameter int MAX_STOPS    = DEF_MAX_STOPS,
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [POS_W-1:0]       sample_value,
    output logic                   done,
    output logic [CHAN_PORT_W-1:0] out_red,
    output logic [CHAN_PORT_W-1:0] out_green,
    output logic [CHAN_PORT_W-1:0] out_blue,
    output logic                   gradient_empty,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [STOP_W-1:0]      cfg_data
);

    localparam int CB      = CHANNEL_BITS;
    localparam int NW      = CB + POS_W;
    localparam int LATENCY = CB + 6;

    // Configuration registers.
    logic [CNT_W-1:0]  stop_count_reg;
    logic [STOP_W-1:0] stop_reg [MAX_STOPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_count_reg <= STOP_COUNT_RESET;
            for (int i = 0; i < MAX_STOPS; i++)
            begin
                stop_reg[i] <= STOP_RESET[i];
            end
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_STOP_COUNT)
            begin
                stop_count_reg <= cfg_data[CNT_W-1:0];
            end
            for (int i = 0; i < MAX_STOPS; i++)
            begin
                if (cfg_index == CFG_INDEX_W'(int'(REG_STOP_0) + i))
                begin
                    stop_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Stage 1: compare the sample against every stop in parallel and pick the
    // first stop above it. When none is above, the last valid stop is used
    // for both ends, which gives a zero-width segment and its color unchanged.
    logic [CNT_W-1:0]     stop_limit;
    logic [MAX_STOPS-1:0] above;
    logic [MAX_STOPS-1:0] first_oh;
    logic [MAX_STOPS-1:0] last_oh;
    logic [MAX_STOPS-1:0] cur_oh_next;
    logic [MAX_STOPS-1:0] prev_oh_next;
    cgl_tag_t             s1_tag_next;

    always_comb
    begin
        stop_limit = (stop_count_reg > CNT_W'(MAX_STOPS)) ? CNT_W'(MAX_STOPS)
                                                         : stop_count_reg;
        for (int i = 0; i < MAX_STOPS; i++)
        begin
            above[i]   = (CNT_W'(i) < stop_limit) &&
                         (sample_value < stop_reg[i][POS_LSB +: POS_W]);
            last_oh[i] = (CNT_W'(i + 1) == stop_limit);
        end
        first_oh = above & (~above + MAX_STOPS'(1));
        if (above != '0)
        begin
            cur_oh_next  = first_oh;
            // Below the first stop, the segment collapses onto that stop.
            prev_oh_next = first_oh[0] ? first_oh : (first_oh >> 1);
        end
        else
        begin
            cur_oh_next  = last_oh;
            prev_oh_next = last_oh;
        end
        s1_tag_next.valid = start;
        s1_tag_next.empty = (stop_limit == '0);
    end

    cgl_tag_t             s1_tag_reg;
    logic [POS_W-1:0]     s1_sample_reg;
    logic [MAX_STOPS-1:0] s1_cur_oh_reg;
    logic [MAX_STOPS-1:0] s1_prev_oh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
        end
        else
        begin
            s1_tag_reg <= s1_tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sample_reg  <= sample_value;
        s1_cur_oh_reg  <= cur_oh_next;
        s1_prev_oh_reg <= prev_oh_next;
    end

    // Stage 2: fetch both stops and form the distances and channel deltas as
    // sign and magnitude. A zero-width segment becomes a zero numerator over a
    // divisor of one, so the channel passes through untouched.
    logic [STOP_W-1:0]             cur_stop;
    logic [STOP_W-1:0]             prev_stop;
    logic [POS_W-1:0]              num_next;
    logic [POS_W:0]                den_diff;
    logic                          den_zero;
    logic [POS_W-1:0]              den_mag_next;
    logic                          den_neg_next;
    logic [NUM_CH-1:0][CB-1:0]     cur_chan_next;
    logic [NUM_CH-1:0][CB-1:0]     dmag_next;
    logic [NUM_CH-1:0]             dneg_next;

    always_comb
    begin
        logic [CB:0] d;
        cur_stop  = '0;
        prev_stop = '0;
        for (int i = 0; i < MAX_STOPS; i++)
        begin
            cur_stop  = cur_stop  | (stop_reg[i] & {STOP_W{s1_cur_oh_reg[i]}});
            prev_stop = prev_stop | (stop_reg[i] & {STOP_W{s1_prev_oh_reg[i]}});
        end
        num_next     = cur_stop[POS_LSB +: POS_W] - s1_sample_reg;
        den_diff     = (POS_W + 1)'(cur_stop[POS_LSB +: POS_W]) -
                       (POS_W + 1)'(prev_stop[POS_LSB +: POS_W]);
        den_zero     = (den_diff == '0);
        den_neg_next = den_diff[POS_W];
        if (den_zero)
        begin
            den_mag_next = POS_W'(1);
        end
        else if (den_neg_next)
        begin
            den_mag_next = POS_W'(-den_diff);
        end
        else
        begin
            den_mag_next = den_diff[POS_W-1:0];
        end
        for (int k = 0; k < NUM_CH; k++)
        begin
            cur_chan_next[k] = cur_stop[(NUM_CH - 1 - k) * CHAN_FIELD_W +: CB];
            d = (CB + 1)'(prev_stop[(NUM_CH - 1 - k) * CHAN_FIELD_W +: CB]) -
                (CB + 1)'(cur_chan_next[k]);
            dneg_next[k] = d[CB];
            if (den_zero)
            begin
                dmag_next[k] = '0;
            end
            else if (d[CB])
            begin
                dmag_next[k] = CB'(-d);
            end
            else
            begin
                dmag_next[k] = d[CB-1:0];
            end
        end
    end

    cgl_tag_t                  s2_tag_reg;
    logic [POS_W-1:0]          s2_num_reg;
    logic [POS_W-1:0]          s2_den_reg;
    logic                      s2_den_neg_reg;
    logic [NUM_CH-1:0][CB-1:0] s2_chan_reg;
    logic [NUM_CH-1:0][CB-1:0] s2_dmag_reg;
    logic [NUM_CH-1:0]         s2_dneg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_tag_reg <= '0;
        end
        else
        begin
            s2_tag_reg <= s1_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_num_reg     <= num_next;
        s2_den_reg     <= den_mag_next;
        s2_den_neg_reg <= den_neg_next;
        s2_chan_reg    <= cur_chan_next;
        s2_dmag_reg    <= dmag_next;
        s2_dneg_reg    <= dneg_next;
    end

    // Stage 3: one small multiplier per channel forms the dividend magnitude.
    logic [NUM_CH-1:0][NW-1:0] prod_next;
    logic [NUM_CH-1:0]         qneg_next;

    always_comb
    begin
        for (int k = 0; k < NUM_CH; k++)
        begin
            prod_next[k] = NW'(s2_dmag_reg[k]) * NW'(s2_num_reg);
            qneg_next[k] = s2_dneg_reg[k] ^ s2_den_neg_reg;
        end
    end

    cgl_tag_t                  s3_tag_reg;
    logic [NUM_CH-1:0][NW-1:0] s3_prod_reg;
    logic [NUM_CH-1:0]         s3_neg_reg;
    logic [POS_W-1:0]          s3_den_reg;
    logic [NUM_CH-1:0][CB-1:0] s3_chan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_tag_reg <= '0;
        end
        else
        begin
            s3_tag_reg <= s2_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_prod_reg <= prod_next;
        s3_neg_reg  <= qneg_next;
        s3_den_reg  <= s2_den_reg;
        s3_chan_reg <= s2_chan_reg;
    end

    // Divide, apply the sign, add to the current stop's channel and clamp.
    cgl_tag_t                  div_tag;
    logic [NUM_CH-1:0][CB-1:0] div_chan;

    cgl_divider #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_tag   (s3_tag_reg),
        .in_num   (s3_prod_reg),
        .in_den   (s3_den_reg),
        .in_neg   (s3_neg_reg),
        .in_chan  (s3_chan_reg),
        .out_tag  (div_tag),
        .out_chan (div_chan)
    );

    // The pipeline advances every cycle, so a new word is always welcome.
    assign busy           = 1'b0;
    assign done           = div_tag.valid;
    assign gradient_empty = div_tag.empty;
    assign out_red        = CHAN_PORT_W'(div_chan[0]);
    assign out_green      = CHAN_PORT_W'(div_chan[1]);
    assign out_blue       = CHAN_PORT_W'(div_chan[2]);

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted word did not complete after the pipeline latency");

    a_stop_select: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_tag_reg.valid && !s1_tag_reg.empty) |->
            ($onehot(s1_cur_oh_reg) && $onehot(s1_prev_oh_reg)))
        else $error("stop search did not select exactly one segment");

    a_empty_black: assert property (@(posedge clk) disable iff (!rst_n)
        (done && gradient_empty) |->
            (out_red == '0 && out_green == '0 && out_blue == '0))
        else $error("empty gradient produced a nonzero color");

endmodule

[tb/cgl_color_monitor.sv]
// Watches the color gradient lookup ports, predicts every color and compares the results.
module cgl_color_monitor
    import cgl_pkg::*;
#(
    parameter int MAX_STOPS    = DEF_MAX_STOPS,
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic [POS_W-1:0]       sample_value,
    input  logic                   done,
    input  logic [CHAN_PORT_W-1:0] out_red,
    input  logic [CHAN_PORT_W-1:0] out_green,
    input  logic [CHAN_PORT_W-1:0] out_blue,
    input  logic                   gradient_empty,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [STOP_W-1:0]      cfg_data,
    output int                     mismatch_count,
    output int                     colors_pending
);

    typedef struct packed {
        logic [CHAN_PORT_W-1:0] red;
        logic [CHAN_PORT_W-1:0] green;
        logic [CHAN_PORT_W-1:0] blue;
        logic                   empty;
    } color_t;

    localparam longint CH_MAX = (longint'(1) << CHANNEL_BITS) - 1;

    logic [CNT_W-1:0]  stop_count;
    logic [STOP_W-1:0] stops [NUM_STOP_REGS];
    color_t            expected_colors [$];

    function automatic longint position_of(input logic [STOP_W-1:0] stop);
        return longint'(stop[POS_LSB +: POS_W]);
    endfunction

    // One channel of the blend, truncating toward zero and clamped to the channel range.
    function automatic logic [CHAN_PORT_W-1:0] blend_channel(
        input logic [CHAN_FIELD_W-1:0] prev_ch,
        input logic [CHAN_FIELD_W-1:0] cur_ch,
        input longint                  num,
        input longint                  den
    );
        longint c;
        longint p;
        longint v;
        c = longint'(cur_ch) & CH_MAX;
        p = longint'(prev_ch) & CH_MAX;
        v = c;
        if (den != 0)
            v = c + ((p - c) * num) / den;
        if (v < 0)
            v = 0;
        if (v > CH_MAX)
            v = CH_MAX;
        return CHAN_PORT_W'(v);
    endfunction

    function automatic color_t color_for_sample(input logic [POS_W-1:0] sample);
        color_t            px;
        int                n;
        int                hit;
        int                i;
        longint            s;
        longint            num;
        longint            den;
        logic [STOP_W-1:0] cur;
        logic [STOP_W-1:0] prev;
        px = '0;
        n  = int'(stop_count);
        if (n > MAX_STOPS)
            n = MAX_STOPS;
        if (n == 0)
        begin
            px.empty = 1'b1;
            return px;
        end
        s   = longint'(sample);
        hit = -1;
        for (i = 0; i < n; i++)
            if (hit < 0 && s < position_of(stops[i]))
                hit = i;
        if (hit < 0)
        begin
            // At or above the last stop: its color, taken as a zero fraction.
            cur  = stops[n - 1];
            prev = cur;
        end
        else
        begin
            cur  = stops[hit];
            prev = (hit == 0) ? cur : stops[hit - 1];
        end
        num = position_of(cur) - s;
        den = position_of(cur) - position_of(prev);
        px.red   = blend_channel(prev[2*CHAN_FIELD_W +: CHAN_FIELD_W],
                                 cur[2*CHAN_FIELD_W +: CHAN_FIELD_W], num, den);
        px.green = blend_channel(prev[CHAN_FIELD_W +: CHAN_FIELD_W],
                                 cur[CHAN_FIELD_W +: CHAN_FIELD_W], num, den);
        px.blue  = blend_channel(prev[0 +: CHAN_FIELD_W], cur[0 +: CHAN_FIELD_W], num, den);
        return px;
    endfunction

    task automatic report_mismatch(input string field, input longint want, input longint got);
        $display("%0t: %s mismatch, expected %0d got %0d", $time, field, want, got);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        color_t want;
        color_t got;
        if (!rst_n)
        begin
            stop_count = STOP_COUNT_RESET;
            for (int i = 0; i < NUM_STOP_REGS; i++)
                stops[i] = STOP_RESET[i];
            expected_colors.delete();
        end
        else
        begin
            if (done)
            begin
                got = '{red: out_red, green: out_green, blue: out_blue, empty: gradient_empty};
                if (expected_colors.size() == 0)
                    report_mismatch("result with no word in flight", 0, 1);
                else
                begin
                    want = expected_colors.pop_front();
                    if (got.red !== want.red)
                        report_mismatch("out_red", want.red, got.red);
                    if (got.green !== want.green)
                        report_mismatch("out_green", want.green, got.green);
                    if (got.blue !== want.blue)
                        report_mismatch("out_blue", want.blue, got.blue);
                    if (got.empty !== want.empty)
                        report_mismatch("gradient_empty", want.empty, got.empty);
                end
            end
            if (start && !busy)
                expected_colors.insert(expected_colors.size(),
                                       color_for_sample(sample_value));
            if (cfg_write)
            begin
                if (cfg_index == REG_STOP_COUNT)
                    stop_count = cfg_data[CNT_W-1:0];
                else
                    stops[int'(cfg_index) - 1] = cfg_data;
            end
        end
        colors_pending = expected_colors.size();
    end

endmodule

[tb/testbench.sv]
// Stimulus and verdict for the color gradient lookup, with the color monitor beside the block.
module testbench;
    import cgl_pkg::*;

    // Extra wait that settle() adds once the last color has come out.
    localparam int LATENCY      = DEF_CHANNEL_BITS + 5;
    localparam int RANDOM_WORDS = 1150;
    localparam int POS_MAX      = (1 << POS_W) - 1;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [POS_W-1:0]       sample_value;
    logic                   done;
    logic [CHAN_PORT_W-1:0] out_red;
    logic [CHAN_PORT_W-1:0] out_green;
    logic [CHAN_PORT_W-1:0] out_blue;
    logic                   gradient_empty;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [STOP_W-1:0]      cfg_data;

    int mismatch_count;
    int colors_pending;
    int words_sent;

    // The gradient that the stimulus has loaded (or is about to load) into the block.
    logic [CNT_W-1:0]  plan_count;
    logic [STOP_W-1:0] plan_stops [NUM_STOP_REGS];

    always #5 clk = ~clk;

    color_gradient_lookup dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .sample_value   (sample_value),
        .done           (done),
        .out_red        (out_red),
        .out_green      (out_green),
        .out_blue       (out_blue),
        .gradient_empty (gradient_empty),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    cgl_color_monitor monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .sample_value   (sample_value),
        .done           (done),
        .out_red        (out_red),
        .out_green      (out_green),
        .out_blue       (out_blue),
        .gradient_empty (gradient_empty),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .colors_pending (colors_pending)
    );

    // A hung handshake or a lost result ends the run here, long after a correct run ends.
    initial
    begin
        #500_000;
        $display("FAIL color_gradient_lookup");
        $finish;
    end

    function automatic logic [STOP_W-1:0] make_stop(
        input int                      pos,
        input logic [CHAN_FIELD_W-1:0] red,
        input logic [CHAN_FIELD_W-1:0] green,
        input logic [CHAN_FIELD_W-1:0] blue
    );
        return {POS_W'(pos), red, green, blue};
    endfunction

    // Writes the stop count and all seven stops from the plan, one register per cycle.
    // The write enable stays high across the burst and drops once at the end.
    // The unused upper bits of the count write carry noise, which the block must ignore.
    task automatic load_gradient();
        logic [STOP_W-1:0] count_word;
        count_word = STOP_W'({$urandom(), $urandom()});
        count_word[CNT_W-1:0] = plan_count;
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_STOP_COUNT;
        cfg_data  <= count_word;
        for (int i = 0; i < NUM_STOP_REGS; i++)
        begin
            @(negedge clk);
            cfg_index <= cfg_reg_t'(int'(REG_STOP_0) + i);
            cfg_data  <= plan_stops[i];
        end
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Presents one sample and returns at the rising edge that accepts it. When gaps are
    // allowed, start drops before about eight words of a hundred, with junk on the
    // sample port meanwhile. Start is otherwise left high, so back to back words
    // stream at full rate.
    task automatic send_word(input logic [POS_W-1:0] value, input bit gaps);
        @(negedge clk);
        if (gaps && $urandom_range(99) < 8)
        begin
            start        <= 1'b0;
            sample_value <= POS_W'($urandom());
            repeat ($urandom_range(3, 1)) @(negedge clk);
        end
        start        <= 1'b1;
        sample_value <= value;
        // Busy only changes at rising edges, so its mid-cycle value decides acceptance.
        while (busy)
            @(negedge clk);
        @(posedge clk);
        words_sent++;
    endtask

    // Stops the stream and waits until every accepted word has produced its color,
    // so that the block is idle before the next register write.
    task automatic settle();
        @(negedge clk);
        start        <= 1'b0;
        sample_value <= POS_W'($urandom());
        wait (colors_pending == 0);
        repeat (LATENCY) @(negedge clk);
    endtask

    // Samples are mostly uniform over the whole range, with many placed on or right
    // next to a stop position, where the search changes its choice of segment, and others at either end of the range.
    function automatic logic [POS_W-1:0] pick_sample();
        int roll;
        int k;
        int p;
        roll = $urandom_range(99);
        if (roll < 55 || plan_count == 0)
            return POS_W'($urandom());
        k = $urandom_range(int'(plan_count) - 1, 0);
        p = int'(plan_stops[k][POS_LSB +: POS_W]);
        if (roll < 90)
            p = p + int'($urandom_range(4)) - 2;
        else if (roll < 95)
            p = 0;
        else
            p = POS_MAX;
        if (p < 0)
            p = 0;
        if (p > POS_MAX)
            p = POS_MAX;
        return POS_W'(p);
    endfunction

    // Builds a random gradient. Most plans have sorted positions that climb in random
    // steps from a random base, some steps being zero so that neighbors coincide. The
    // rest keep fully random positions, which leaves the stops unsorted. Colors are random
    // in every bit, and the stops beyond the count follow the same rules as the others.
    function automatic void random_plan();
        int mode;
        int pos;
        int span;
        mode = $urandom_range(99);
        if (mode < 5)
            plan_count = '0;
        else if (mode < 10)
            plan_count = CNT_W'(1);
        else
            plan_count = CNT_W'($urandom_range(7, 2));
        pos  = $urandom_range(POS_MAX / 2);
        span = (POS_MAX - pos) / NUM_STOP_REGS;
        for (int i = 0; i < NUM_STOP_REGS; i++)
        begin
            plan_stops[i] = STOP_W'({$urandom(), $urandom()});
            if (mode < 80)
            begin
                if (i > 0 && $urandom_range(9) != 0)
                    pos = pos + int'($urandom_range(span));
                plan_stops[i][POS_LSB +: POS_W] = POS_W'(pos);
            end
        end
    endfunction

    initial
    begin
        logic [POS_W-1:0] probe [$];
        int               phase;
        int               quota;
        int               target;

        // Every input is known from time zero; reset is held low at the start.
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        sample_value = '0;
        cfg_write    = 1'b0;
        cfg_index    = REG_STOP_COUNT;
        cfg_data     = '0;
        words_sent   = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // The default gradient straight out of reset: blue, cyan, green, yellow and red
        // at quarter steps. The probes hit each stop exactly, just below and between them,
        // and the top of the sample range above the last stop.
        plan_count = STOP_COUNT_RESET;
        for (int i = 0; i < NUM_STOP_REGS; i++)
            plan_stops[i] = STOP_RESET[i];
        probe = '{17'h00000, 17'h00001, 17'h03FFF, 17'h04000, 17'h06000, 17'h08000,
                  17'h0A123, 17'h0C000, 17'h0FFFF, 17'h10000, 17'h1FFFF};
        foreach (probe[i])
            send_word(probe[i], 1'b0);
        settle();

        // Empty gradient: zero colors with the empty flag, at both ends of the range.
        plan_count = '0;
        load_gradient();
        probe = '{17'h00000, 17'h1FFFF};
        foreach (probe[i])
            send_word(probe[i], 1'b0);
        settle();

        // A single stop: below it the first color, at or above it the last color.
        plan_count    = CNT_W'(1);
        plan_stops[0] = make_stop('h08000, 8'hFF, 8'h00, 8'hAA);
        load_gradient();
        probe = '{17'h07FFF, 17'h08000, 17'h1FFFF};
        foreach (probe[i])
            send_word(probe[i], 1'b0);
        settle();

        // All seven stops, with coinciding positions, channel extremes and stops at the
        // very top of the position range.
        plan_count    = CNT_W'(7);
        plan_stops[0] = make_stop('h00000, 8'hFF, 8'hFF, 8'hFF);
        plan_stops[1] = make_stop('h00000, 8'h00, 8'h00, 8'h00);
        plan_stops[2] = make_stop('h00001, 8'hFF, 8'h00, 8'hFF);
        plan_stops[3] = make_stop('h10000, 8'h00, 8'hFF, 8'h00);
        plan_stops[4] = make_stop('h10000, 8'hFF, 8'hFF, 8'hFF);
        plan_stops[5] = make_stop('h1FFFE, 8'h00, 8'h00, 8'h00);
        plan_stops[6] = make_stop('h1FFFF, 8'hFF, 8'hFF, 8'hFF);
        load_gradient();
        probe = '{17'h00000, 17'h08000, 17'h1FFFE, 17'h1FFFF};
        foreach (probe[i])
            send_word(probe[i], 1'b0);
        settle();

        // Unsorted stops: the search still takes the first stop above the sample, so a
        // low sample lands on the first stop and a high one blends from the out-of-order stop.
        plan_count    = CNT_W'(3);
        plan_stops[0] = make_stop('h08000, 8'hFF, 8'h00, 8'h00);
        plan_stops[1] = make_stop('h02000, 8'h00, 8'hFF, 8'h00);
        plan_stops[2] = make_stop('h18000, 8'h00, 8'h00, 8'hFF);
        load_gradient();
        probe = '{17'h01000, 17'h09000};
        foreach (probe[i])
            send_word(probe[i], 1'b0);
        settle();

        // Random gradients, each followed by a random run of samples. Phases four to six
        // stream without any gap on the input side.
        phase  = 0;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target)
        begin
            random_plan();
            load_gradient();
            quota = $urandom_range(90, 30);
            repeat (quota)
                send_word(pick_sample(), !(phase >= 4 && phase < 7));
            settle();
            phase++;
        end

        if (mismatch_count == 0)
            $display("PASS color_gradient_lookup");
        else
            $display("FAIL color_gradient_lookup");
        $finish;
    end

endmodule
